>>> src/impact_magnitude_peak_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the impact magnitude peak detector
// Both macros sample on clk_i and stay quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IMPACT_MAGNITUDE_PEAK_DETECTOR_ASSERT_SVH
`define IMPACT_MAGNITUDE_PEAK_DETECTOR_ASSERT_SVH

// Same-cycle implication
`define IMP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/imp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imp_pkg
// Shared constants, types and helpers of the impact magnitude peak detector.
// ----------------------------------------------------------------------------
package imp_pkg;

  // Calibration length (power of two: bias uses a floor shift)
  localparam int unsigned CAL_SAMPLES = 512;
  localparam int unsigned CAL_SHIFT   = $clog2(CAL_SAMPLES);
  localparam int unsigned CNT_W       = $clog2(CAL_SAMPLES + 1);

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned CORR_W  = 17;
  localparam int unsigned BIAS_W  = 17;
  localparam int unsigned DIFF_W  = BIAS_W + 1;
  localparam int unsigned SUM_W   = CORR_W + CAL_SHIFT;
  localparam int unsigned ABS_W   = CORR_W - 1;
  localparam int unsigned SQ_W    = 2 * ABS_W;
  localparam int unsigned MAG_W   = 17;
  localparam int unsigned RAD_W   = 2 * MAG_W;
  localparam int unsigned REM_W   = MAG_W + 3;
  localparam int unsigned STEP_W  = $clog2(MAG_W);
  localparam int unsigned THR_W   = 17;
  localparam int unsigned GRAV_W  = 15;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(2506);
  localparam logic [GRAV_W-1:0] GRAV_RESET = GRAV_W'(2048);

  localparam logic signed [DIFF_W-1:0] CORR_HI = DIFF_W'(65535);
  localparam logic signed [DIFF_W-1:0] CORR_LO = DIFF_W'(-65535);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_GRAVITY   = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORR,
    S_SQ,
    S_ROOT,
    S_OUT
  } state_e;

  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [BIAS_W-1:0] bias_t;
  typedef logic signed [CORR_W-1:0] corr_t;

  // Calibration status toward the sequencer
  typedef struct packed {
    logic  done;
    bias_t bias_x;
    bias_t bias_y;
    bias_t bias_z;
  } cal_stat_t;

  // Clamp a raw-minus-bias difference to the symmetric corrected range
  function automatic corr_t sat_corr(input logic signed [DIFF_W-1:0] d);
    corr_t r;
    if (d > CORR_HI) begin
      r = CORR_W'(CORR_HI);
    end else if (d < CORR_LO) begin
      r = CORR_W'(CORR_LO);
    end else begin
      r = CORR_W'(d);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/impact_magnitude_peak_detector.sv
// A measurement request passes bias correction, then the shared 16x16 squaring
//   multiplier, then the square-root unit, which retires two radicand bits per cycle
//   (17 steps) and is the longest step; a new measurement request is taken only once
//   the previous result has been loaded into the output register.
// Calibration requests (the first 512 after reset) are taken one per cycle, no result.
// Reset (rst_ni low, asynchronous) clears calibration sums, biases, peak and control.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// impact_magnitude_peak_detector
// Three-axis accelerometer calibration, bias removal, vector magnitude,
// running peak and impact flag.
// ----------------------------------------------------------------------------
`include "impact_magnitude_peak_detector_assert.svh"

module impact_magnitude_peak_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [imp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [imp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // sample request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [imp_pkg::RAW_W-1:0]   accel_x_i,
  input  logic signed [imp_pkg::RAW_W-1:0]   accel_y_i,
  input  logic signed [imp_pkg::RAW_W-1:0]   accel_z_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [imp_pkg::CORR_W-1:0]  corrected_x_o,
  output logic signed [imp_pkg::CORR_W-1:0]  corrected_y_o,
  output logic signed [imp_pkg::CORR_W-1:0]  corrected_z_o,
  output logic [imp_pkg::MAG_W-1:0]          magnitude_o,
  output logic [imp_pkg::MAG_W-1:0]          peak_magnitude_o,
  output logic                               impact_o
);

  // --------------------------------------------------------------------------
  // Configuration registers: always ready, unknown indexes drop silently
  // --------------------------------------------------------------------------
  logic [imp_pkg::THR_W-1:0]  thr_q;
  logic [imp_pkg::GRAV_W-1:0] grav_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= imp_pkg::THR_RESET;
      grav_q <= imp_pkg::GRAV_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        imp_pkg::CFG_THRESHOLD: thr_q  <= cfg_data_i[imp_pkg::THR_W-1:0];
        imp_pkg::CFG_GRAVITY:   grav_q <= cfg_data_i[imp_pkg::GRAV_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  imp_pkg::state_e              state_q, state_d;
  logic [1:0]                   sq_cnt_q, sq_cnt_d;
  logic                         in_acc;
  logic                         load;
  logic                         sq_start;
  logic                         sq_done;
  logic [imp_pkg::MAG_W-1:0]    root;
  imp_pkg::cal_stat_t           cal_stat;

  imp_pkg::raw_t                raw_x_q, raw_y_q, raw_z_q;
  imp_pkg::corr_t               corr_x_q, corr_y_q, corr_z_q;
  imp_pkg::corr_t               corr_x, corr_y, corr_z;
  logic [imp_pkg::ABS_W-1:0]    abs_x_q, abs_y_q, abs_z_q;
  logic [imp_pkg::ABS_W-1:0]    mul_op;
  logic [imp_pkg::SQ_W-1:0]     prod_q;
  logic [imp_pkg::RAD_W-1:0]    acc_q;
  logic [imp_pkg::RAD_W-1:0]    radicand;

  logic                         out_valid_q;
  imp_pkg::corr_t               out_x_q, out_y_q, out_z_q;
  logic [imp_pkg::MAG_W-1:0]    mag_q;
  logic [imp_pkg::MAG_W-1:0]    peak_q;
  logic                         impact_q;

  assign in_acc = in_valid_i && !in_stall_o;

  // calibration: every request until the count fills goes to the summers
  imp_calib u_calib (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (in_acc),
    .ax_i      (accel_x_i),
    .ay_i      (accel_y_i),
    .az_i      (accel_z_i),
    .gravity_i (grav_q),
    .stat_o    (cal_stat)
  );

  // bias removal with symmetric saturation
  assign corr_x = imp_pkg::sat_corr(imp_pkg::DIFF_W'(raw_x_q) - imp_pkg::DIFF_W'(cal_stat.bias_x));
  assign corr_y = imp_pkg::sat_corr(imp_pkg::DIFF_W'(raw_y_q) - imp_pkg::DIFF_W'(cal_stat.bias_y));
  assign corr_z = imp_pkg::sat_corr(imp_pkg::DIFF_W'(raw_z_q) - imp_pkg::DIFF_W'(cal_stat.bias_z));

  // shared squaring multiplier: operand picked by the sequence count
  always_comb begin
    case (sq_cnt_q)
      2'd0:    mul_op = abs_x_q;
      2'd1:    mul_op = abs_y_q;
      2'd2:    mul_op = abs_z_q;
      default: mul_op = '0;
    endcase
  end

  // final partial product joins the sum on its way into the root unit
  assign radicand = acc_q + imp_pkg::RAD_W'(prod_q);

  imp_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (radicand),
    .done_o     (sq_done),
    .root_o     (root)
  );

  // --------------------------------------------------------------------------
  // Next state and strobes
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    sq_cnt_d   = sq_cnt_q;
    sq_start   = 1'b0;
    load       = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      imp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        // calibration requests stay in idle, measurements start the sequence
        if (in_valid_i && cal_stat.done) begin
          state_d = imp_pkg::S_CORR;
        end
      end
      imp_pkg::S_CORR: begin
        sq_cnt_d = '0;
        state_d  = imp_pkg::S_SQ;
      end
      imp_pkg::S_SQ: begin
        sq_cnt_d = sq_cnt_q + 2'd1;
        if (sq_cnt_q == 2'd3) begin
          sq_start = 1'b1;
          state_d  = imp_pkg::S_ROOT;
        end
      end
      imp_pkg::S_ROOT: begin
        if (sq_done) begin
          state_d = imp_pkg::S_OUT;
        end
      end
      imp_pkg::S_OUT: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = imp_pkg::S_IDLE;
        end
      end
      default: state_d = imp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imp_pkg::S_IDLE;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      peak_q      <= '0;
    end else begin
      state_q  <= state_d;
      sq_cnt_q <= sq_cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
        if (root > peak_q) begin
          peak_q <= root;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_x_q <= accel_x_i;
      raw_y_q <= accel_y_i;
      raw_z_q <= accel_z_i;
    end
    if (state_q == imp_pkg::S_CORR) begin
      corr_x_q <= corr_x;
      corr_y_q <= corr_y;
      corr_z_q <= corr_z;
      abs_x_q  <= corr_x[imp_pkg::CORR_W-1] ? imp_pkg::ABS_W'(-corr_x) : imp_pkg::ABS_W'(corr_x);
      abs_y_q  <= corr_y[imp_pkg::CORR_W-1] ? imp_pkg::ABS_W'(-corr_y) : imp_pkg::ABS_W'(corr_y);
      abs_z_q  <= corr_z[imp_pkg::CORR_W-1] ? imp_pkg::ABS_W'(-corr_z) : imp_pkg::ABS_W'(corr_z);
      acc_q    <= '0;
    end
    if (state_q == imp_pkg::S_SQ) begin
      prod_q <= mul_op * mul_op;
      // first cycle has no product yet to accumulate
      if (sq_cnt_q != 2'd0) begin
        acc_q <= acc_q + imp_pkg::RAD_W'(prod_q);
      end
    end
    if (load) begin
      out_x_q  <= corr_x_q;
      out_y_q  <= corr_y_q;
      out_z_q  <= corr_z_q;
      mag_q    <= root;
      impact_q <= (root >= thr_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign corrected_x_o    = out_x_q;
  assign corrected_y_o    = out_y_q;
  assign corrected_z_o    = out_z_q;
  assign magnitude_o      = mag_q;
  assign peak_magnitude_o = peak_q;
  assign impact_o         = impact_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `IMP_ASSERT_IMP(a_peak_covers_mag, out_valid_o, peak_magnitude_o >= magnitude_o,
    "peak below current magnitude")
  `IMP_ASSERT_IMP(a_no_result_in_cal, !cal_stat.done, !out_valid_o,
    "result during calibration")
  `IMP_ASSERT_NEXT(a_busy_after_meas, in_acc && cal_stat.done, in_stall_o,
    "measurement did not lock the input")
  `IMP_ASSERT_IMP(a_root_done_in_wait, sq_done, state_q == imp_pkg::S_ROOT,
    "root finished outside its wait state")

endmodule
`default_nettype wire

>>> src/imp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imp_sqrt
// Bit-serial floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module imp_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [imp_pkg::RAD_W-1:0]      radicand_i,
  output logic                           done_o,
  output logic [imp_pkg::MAG_W-1:0]      root_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [imp_pkg::STEP_W-1:0]    step_q, step_d;
  logic [imp_pkg::RAD_W-1:0]     rad_q, rad_d;
  logic [imp_pkg::REM_W-1:0]     rem_q, rem_d;
  logic [imp_pkg::MAG_W-1:0]     root_q, root_d;
  logic [imp_pkg::REM_W-1:0]     rem_sh, trial;
  logic                          last;

  assign last   = (step_q == imp_pkg::STEP_W'(imp_pkg::MAG_W - 1));
  assign rem_sh = {rem_q[imp_pkg::REM_W-3:0], rad_q[imp_pkg::RAD_W-1 -: 2]};
  assign trial  = imp_pkg::REM_W'({root_q, 2'b01});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[imp_pkg::RAD_W-3:0], 2'b00};
      step_d = step_q + imp_pkg::STEP_W'(1);
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[imp_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[imp_pkg::MAG_W-2:0], 1'b0};
      end
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

>>> src/imp_calib.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imp_calib
// Sums the calibration samples and derives the per-axis bias.
// ----------------------------------------------------------------------------
module imp_calib (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  imp_pkg::raw_t                 ax_i,
  input  imp_pkg::raw_t                 ay_i,
  input  imp_pkg::raw_t                 az_i,
  input  logic [imp_pkg::GRAV_W-1:0]    gravity_i,
  output imp_pkg::cal_stat_t            stat_o
);

  logic [imp_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [imp_pkg::SUM_W-1:0]   sum_x_q, sum_y_q, sum_z_q;
  logic signed [imp_pkg::SUM_W-1:0]   sum_x_d, sum_y_d, sum_z_d;
  imp_pkg::bias_t                     bias_x_q, bias_y_q, bias_z_q;
  logic signed [imp_pkg::SUM_W-1:0]   grav_ext;
  logic                               done, last;

  assign done = (cnt_q == imp_pkg::CNT_W'(imp_pkg::CAL_SAMPLES));
  assign last = (cnt_q == imp_pkg::CNT_W'(imp_pkg::CAL_SAMPLES - 1));

  assign grav_ext = imp_pkg::SUM_W'(signed'({1'b0, gravity_i}));
  assign sum_x_d  = sum_x_q + imp_pkg::SUM_W'(ax_i);
  assign sum_y_d  = sum_y_q + imp_pkg::SUM_W'(ay_i);
  assign sum_z_d  = sum_z_q + imp_pkg::SUM_W'(az_i) - grav_ext;
  assign cnt_d    = cnt_q + imp_pkg::CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_z_q  <= '0;
      bias_x_q <= '0;
      bias_y_q <= '0;
      bias_z_q <= '0;
    end else if (take_i && !done) begin
      cnt_q   <= cnt_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      sum_z_q <= sum_z_d;
      // floor mean: arithmetic shift of the final sums
      if (last) begin
        bias_x_q <= imp_pkg::BIAS_W'(sum_x_d >>> imp_pkg::CAL_SHIFT);
        bias_y_q <= imp_pkg::BIAS_W'(sum_y_d >>> imp_pkg::CAL_SHIFT);
        bias_z_q <= imp_pkg::BIAS_W'(sum_z_d >>> imp_pkg::CAL_SHIFT);
      end
    end
  end

  assign stat_o.done   = done;
  assign stat_o.bias_x = bias_x_q;
  assign stat_o.bias_y = bias_y_q;
  assign stat_o.bias_z = bias_z_q;

endmodule
`default_nettype wire
